// File: src/sw95_pkg.sv
package sw95_pkg;

    localparam int RING_DEPTH  = 120;
    localparam int SAMPLE_BITS = 24;

    // Port field widths
    localparam int WIN_W      = 7;
    localparam int TH_W       = 24;
    localparam int US_W       = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    // Internal widths
    localparam int CNT_W  = $clog2(RING_DEPTH + 1);
    localparam int ADDR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int BIT_W  = (SAMPLE_BITS > 1) ? $clog2(SAMPLE_BITS) : 1;
    localparam int WIDE_W = (CNT_W > WIN_W) ? CNT_W : WIN_W;
    localparam int VAL_W  = (SAMPLE_BITS > US_W) ? SAMPLE_BITS : US_W;

    // Rank = floor(95 * (n - 1) / 100): the divide by 100 is a multiply by a
    // rounded-up reciprocal of 2^24 / 100, exact for every n up to 1024.
    localparam int K_NUM   = 95;
    localparam int K_MUL   = 167773;
    localparam int K_SHIFT = 24;
    localparam int X_W     = CNT_W + 7;
    localparam int PROD_W  = X_W + 18;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LAST  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_COUNT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD_US = 2'd2;

    localparam logic [WIN_W-1:0] RST_WINDOW_LAST  = 7'd20;
    localparam logic [WIN_W-1:0] RST_MIN_COUNT    = 7'd5;
    localparam logic [TH_W-1:0]  RST_THRESHOLD_US = 24'd10000;

    typedef struct packed {
        logic [WIN_W-1:0] window_last;
        logic [WIN_W-1:0] min_count;
        logic [TH_W-1:0]  threshold_us;
    } t_cfg;

    typedef struct packed {
        logic write;      // store sample, advance pointer and count
        logic load_k;     // load target rank from window size
        logic scan_init;  // rewind read pointer, clear bin count
        logic issue;      // read one window entry
        logic decide;     // settle one result bit, rewind for next pass
        logic finish;     // apply degrade check
    } t_cmd;

    typedef struct packed {
        logic issue_last;
        logic bit_last;
    } t_sts;

    function automatic logic [CNT_W-1:0] rank_of(input logic [CNT_W-1:0] n);
        logic [X_W-1:0]    x;
        logic [PROD_W-1:0] prod;
        x    = X_W'(n - CNT_W'(1)) * X_W'(K_NUM);
        prod = PROD_W'(x) * PROD_W'(K_MUL);
        return CNT_W'(prod >> K_SHIFT);
    endfunction

endpackage

// File: src/sw95_ctrl.sv
module sw95_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_out_free,
    input  sw95_pkg::t_sts  i_sts,
    output sw95_pkg::t_cmd  o_cmd,
    output logic            o_in_ready,
    output logic            o_out_load
);
    import sw95_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_PREP   = 3'd1;
    localparam logic [2:0] ST_SCAN   = 3'd2;
    localparam logic [2:0] ST_DRAIN  = 3'd3;
    localparam logic [2:0] ST_DECIDE = 3'd4;
    localparam logic [2:0] ST_FINISH = 3'd5;
    localparam logic [2:0] ST_OUT    = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        o_out_load = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.write = 1'b1;
                    n_state     = ST_PREP;
                end
            end
            ST_PREP: begin
                o_cmd.load_k    = 1'b1;
                o_cmd.scan_init = 1'b1;
                n_state         = ST_SCAN;
            end
            ST_SCAN: begin
                o_cmd.issue = 1'b1;
                if (i_sts.issue_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_DECIDE;
            end
            ST_DECIDE: begin
                o_cmd.decide = 1'b1;
                n_state      = i_sts.bit_last ? ST_FINISH : ST_SCAN;
            end
            ST_FINISH: begin
                o_cmd.finish = 1'b1;
                n_state      = ST_OUT;
            end
            ST_OUT: begin
                if (i_out_free) begin
                    o_out_load = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: src/sw95_dp.sv
module sw95_dp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  sw95_pkg::t_cmd              i_cmd,
    input  sw95_pkg::t_cfg              i_cfg,
    input  logic [sw95_pkg::US_W-1:0]   i_sample_us,
    output sw95_pkg::t_sts              o_sts,
    output logic [sw95_pkg::US_W-1:0]   o_p95_us,
    output logic [sw95_pkg::CNT_W-1:0]  o_count,
    output logic [sw95_pkg::CNT_W-1:0]  o_n,
    output logic                        o_degraded
);
    import sw95_pkg::*;

    localparam logic [SAMPLE_BITS-1:0] ONES = '1;

    logic [SAMPLE_BITS-1:0] mem [RING_DEPTH];
    logic [SAMPLE_BITS-1:0] r_rd_data;

    logic [ADDR_W-1:0]      r_wp;
    logic [ADDR_W-1:0]      r_newest;
    logic [ADDR_W-1:0]      r_rd_addr;
    logic [CNT_W-1:0]       r_count;
    logic [CNT_W-1:0]       r_n;
    logic [CNT_W-1:0]       r_k;
    logic [CNT_W-1:0]       r_idx;
    logic [CNT_W-1:0]       r_zero_cnt;
    logic [BIT_W-1:0]       r_bit;
    logic [SAMPLE_BITS-1:0] r_prefix;
    logic                   r_rd_v;
    logic                   r_degraded;

    logic [CNT_W-1:0]       w_count_inc;
    logic [WIDE_W-1:0]      w_count_wide;
    logic [WIDE_W-1:0]      w_win_wide;
    logic [CNT_W-1:0]       w_n;
    logic [VAL_W-1:0]       w_sample_wide;
    logic [VAL_W-1:0]       w_prefix_wide;
    logic                   w_match;
    logic [SAMPLE_BITS-1:0] n_prefix;
    logic [ADDR_W-1:0]      w_rd_prev;

    assign w_count_inc   = (r_count < CNT_W'(RING_DEPTH)) ? r_count + CNT_W'(1) : r_count;
    assign w_count_wide  = WIDE_W'(w_count_inc);
    assign w_win_wide    = WIDE_W'(i_cfg.window_last);
    assign w_n           = (w_win_wide != '0 && w_win_wide < w_count_wide) ?
                           CNT_W'(w_win_wide) : w_count_inc;
    assign w_sample_wide = VAL_W'(i_sample_us);
    assign w_prefix_wide = VAL_W'(r_prefix);

    // Entry sits in the current bin: same upper bits as the prefix, zero at r_bit.
    assign w_match   = ((r_rd_data ^ r_prefix) & (ONES << r_bit)) == '0;
    assign w_rd_prev = (r_rd_addr == '0) ? ADDR_W'(RING_DEPTH - 1) : r_rd_addr - ADDR_W'(1);

    always_comb begin
        n_prefix = r_prefix;
        if (r_k >= r_zero_cnt) begin
            n_prefix[r_bit] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.write) begin
            mem[r_wp] <= w_sample_wide[SAMPLE_BITS-1:0];
        end
        if (i_cmd.issue) begin
            r_rd_data <= mem[r_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp       <= '0;
            r_count    <= '0;
            r_n        <= '0;
            r_rd_v     <= 1'b0;
            r_degraded <= 1'b0;
        end else begin
            r_rd_v <= i_cmd.issue;
            if (i_cmd.write) begin
                r_wp    <= (r_wp == ADDR_W'(RING_DEPTH - 1)) ? '0 : r_wp + ADDR_W'(1);
                r_count <= w_count_inc;
                r_n     <= w_n;
            end
            if (i_cmd.finish && WIDE_W'(r_count) >= WIDE_W'(i_cfg.min_count)
                    && w_prefix_wide > VAL_W'(i_cfg.threshold_us)) begin
                r_degraded <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.write) begin
            r_newest <= r_wp;
            r_prefix <= '0;
            r_bit    <= BIT_W'(SAMPLE_BITS - 1);
        end
        if (i_cmd.load_k) begin
            r_k <= rank_of(r_n);
        end
        if (i_cmd.scan_init || (i_cmd.decide && !o_sts.bit_last)) begin
            r_rd_addr  <= r_newest;
            r_idx      <= '0;
            r_zero_cnt <= '0;
        end else begin
            if (i_cmd.issue) begin
                r_rd_addr <= w_rd_prev;
                r_idx     <= r_idx + CNT_W'(1);
            end
            if (r_rd_v && w_match) begin
                r_zero_cnt <= r_zero_cnt + CNT_W'(1);
            end
        end
        if (i_cmd.decide) begin
            r_prefix <= n_prefix;
            if (r_k >= r_zero_cnt) begin
                r_k <= r_k - r_zero_cnt;
            end
            if (r_bit != '0) begin
                r_bit <= r_bit - BIT_W'(1);
            end
        end
    end

    assign o_sts.issue_last = (r_idx == r_n - CNT_W'(1));
    assign o_sts.bit_last   = (r_bit == '0);
    assign o_p95_us         = w_prefix_wide[US_W-1:0];
    assign o_count          = r_count;
    assign o_n              = r_n;
    assign o_degraded       = r_degraded;

endmodule

// File: src/sliding_window_p95_monitor.sv
// Sliding-window 95th-percentile latency monitor.
// Input channel (i_in_valid / o_in_ready): one beat carries one latency
// sample in microseconds; it is written into a 120-entry ring, oldest
// entry overwritten once the ring is full.
// Output channel (o_out_valid / i_out_ready): one beat per sample with the
// percentile of the newest window_last samples (all stored when 0), the
// stored count, the window size used and the sticky degrade flag.
// Config channel (i_cfg_valid / o_cfg_ready): index 0 window_last,
// 1 min_count, 2 threshold_us; other indexes are dropped. Write only idle.
// The rank is found by a radix select, one result bit per pass over the
// window through the ring's single read port.
// One sample is in flight at a time; the next is taken once the result sits
// in the output register, so a stalled receiver holds at most one result
// there and blocks only the sample after next.
// Reset: ring pointer, count and degrade flag clear, registers return to
// window_last 20, min_count 5, threshold_us 10000. Ring contents are left.
module sliding_window_p95_monitor (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [sw95_pkg::US_W-1:0]         i_sample_us,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [sw95_pkg::US_W-1:0]         o_p95_us,
    output logic [sw95_pkg::WIN_W-1:0]        o_sample_count,
    output logic [sw95_pkg::WIN_W-1:0]        o_window_used,
    output logic                              o_degraded,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [sw95_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [sw95_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import sw95_pkg::*;

    t_cfg              r_cfg;
    t_cmd              w_cmd;
    t_sts              w_sts;
    logic              w_out_free;
    logic              w_out_load;
    logic [US_W-1:0]   w_p95;
    logic [CNT_W-1:0]  w_count;
    logic [CNT_W-1:0]  w_n;
    logic [WIDE_W-1:0] w_count_wide;
    logic [WIDE_W-1:0] w_n_wide;
    logic              w_degraded;

    logic              r_out_valid;
    logic [US_W-1:0]   r_out_p95;
    logic [WIN_W-1:0]  r_out_count;
    logic [WIN_W-1:0]  r_out_n;
    logic              r_out_deg;

    // Config writes are registered directly; always ready.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.window_last  <= RST_WINDOW_LAST;
            r_cfg.min_count    <= RST_MIN_COUNT;
            r_cfg.threshold_us <= RST_THRESHOLD_US;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_WINDOW_LAST:  r_cfg.window_last  <= i_cfg_data[WIN_W-1:0];
                CFG_MIN_COUNT:    r_cfg.min_count    <= i_cfg_data[WIN_W-1:0];
                CFG_THRESHOLD_US: r_cfg.threshold_us <= i_cfg_data[TH_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Output register is free when empty or being drained this cycle.
    assign w_out_free = !r_out_valid || i_out_ready;

    sw95_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_out_free (w_out_free),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd),
        .o_in_ready (o_in_ready),
        .o_out_load (w_out_load)
    );

    sw95_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_cfg       (r_cfg),
        .i_sample_us (i_sample_us),
        .o_sts       (w_sts),
        .o_p95_us    (w_p95),
        .o_count     (w_count),
        .o_n         (w_n),
        .o_degraded  (w_degraded)
    );

    assign w_count_wide = WIDE_W'(w_count);
    assign w_n_wide     = WIDE_W'(w_n);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Hold payload until the next result replaces it.
    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_p95   <= w_p95;
            r_out_count <= w_count_wide[WIN_W-1:0];
            r_out_n     <= w_n_wide[WIN_W-1:0];
            r_out_deg   <= w_degraded;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_p95_us       = r_out_p95;
    assign o_sample_count = r_out_count;
    assign o_window_used  = r_out_n;
    assign o_degraded     = r_out_deg;

`ifndef NO_ASSERTIONS
    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_load |-> w_out_free)
        else $error("result loaded over an untaken result");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("second sample taken while one is in flight");

    a_window_in_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_n <= w_count)
        else $error("window larger than stored count");

    a_degrade_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> !$fell(w_degraded))
        else $error("degrade flag cleared outside reset");
`endif

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import sw95_pkg::*;

    localparam int CYCLE_LIMIT    = 2_000_000;
    // Covers the worst single-sample computation, rounded up.
    localparam int TAIL_CYCLES    = 3000;
    localparam int RANDOM_SAMPLES = 120;
    localparam int PRINT_CAP      = 100;

    // Index 3 decodes to no register; writes there must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

    // Fields of one output beat.
    typedef struct packed {
        logic [US_W-1:0]  p95_us;
        logic [WIN_W-1:0] sample_count;
        logic [WIN_W-1:0] window_used;
        logic             degraded;
    } t_window_stats;

    // DUT ports; the inputs are all known from time zero.
    logic                  i_clk          = 1'b0;
    logic                  i_rst_n        = 1'b0;
    logic                  i_in_valid     = 1'b0;
    logic                  o_in_ready;
    logic [US_W-1:0]       i_sample_us    = '0;
    logic                  o_out_valid;
    logic                  i_out_ready    = 1'b0;
    logic [US_W-1:0]       o_p95_us;
    logic [WIN_W-1:0]      o_sample_count;
    logic [WIN_W-1:0]      o_window_used;
    logic                  o_degraded;
    logic                  i_cfg_valid    = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index    = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data     = '0;

    // Samples waiting for the driver, and predicted beats waiting for the DUT.
    logic [US_W-1:0] sample_feed_q[$];
    t_window_stats   window_stats_q[$];

    // Shadow of the block: ring, pointer, fill count, sticky flag, registers.
    logic [US_W-1:0]  hist_ring [RING_DEPTH];
    int               hist_wp;
    int               hist_count;
    logic             hist_degraded;
    logic [WIN_W-1:0] cfg_window;
    logic [WIN_W-1:0] cfg_min_count;
    logic [TH_W-1:0]  cfg_threshold;

    // Beat counters shared between driver, receiver and monitor.
    int samples_offered = 0;
    int samples_taken   = 0;
    int results_got     = 0;
    int results_seen    = 0;
    int reg_writes      = 0;
    int error_count     = 0;
    int cycle_count     = 0;

    // Idle control for both channels.
    int gap_left  = 0;
    int out_hold  = 0;
    bit in_burst  = 1'b0;
    bit out_burst = 1'b0;

    // Run statistics for the closing summary.
    int widest_window = 0;
    bit saw_full_ring = 1'b0;
    bit saw_degraded  = 1'b0;

    t_window_stats want_stats;

    sliding_window_p95_monitor dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_sample_us    (i_sample_us),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_p95_us       (o_p95_us),
        .o_sample_count (o_sample_count),
        .o_window_used  (o_window_used),
        .o_degraded     (o_degraded),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Push one sample into the shadow ring and work out the beat it causes:
    // the rank floor(95 * (n - 1) / 100) element of the newest n samples.
    function automatic t_window_stats predict_window_stats(input logic [US_W-1:0] sample);
        logic [US_W-1:0] win_vals [RING_DEPTH];
        t_window_stats   r;
        int              n;
        int              k;
        int              below;
        int              not_above;
        hist_ring[hist_wp] = sample;
        hist_wp = (hist_wp == RING_DEPTH - 1) ? 0 : hist_wp + 1;
        if (hist_count < RING_DEPTH) begin
            hist_count = hist_count + 1;
        end
        n = hist_count;
        if (cfg_window != 0 && cfg_window < n) begin
            n = int'(cfg_window);
        end
        // Gather the window newest first.
        for (int i = 0; i < n; i++) begin
            win_vals[i] = hist_ring[(hist_wp + RING_DEPTH - 1 - i) % RING_DEPTH];
        end
        k = (95 * (n - 1)) / 100;
        r.p95_us = '0;
        // An element sits at rank k when fewer than k+1 values lie below it
        // and more than k values lie at or below it; ties all qualify.
        for (int i = 0; i < n; i++) begin
            below     = 0;
            not_above = 0;
            for (int j = 0; j < n; j++) begin
                if (win_vals[j] < win_vals[i]) below++;
                if (win_vals[j] <= win_vals[i]) not_above++;
            end
            if (below <= k && k < not_above) r.p95_us = win_vals[i];
        end
        if (hist_count >= cfg_min_count && r.p95_us > cfg_threshold) begin
            hist_degraded = 1'b1;
        end
        r.sample_count = WIN_W'(hist_count);
        r.window_used  = WIN_W'(n);
        r.degraded     = hist_degraded;
        return r;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        if (error_count < PRINT_CAP) begin
            $display("[%0t] result %0d: %s got %0d expected %0d",
                     $realtime, results_got, field, got, want);
        end
        error_count++;
    endtask

    // Queue one sample for the driver.
    task automatic feed_sample(input logic [US_W-1:0] value);
        sample_feed_q.insert(sample_feed_q.size(), value);
    endtask

    // Issue one register write beat and hold it until accepted.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Hold until the feed is empty and every predicted beat has come back.
    // Every sample yields a beat, so the block is idle once this returns.
    task automatic wait_drain();
        while (sample_feed_q.size() != 0 || samples_taken != samples_offered ||
               window_stats_q.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Input driver: change at the falling edge, one sample per beat, with a
    // random gap after each sample and occasional runs with no gaps.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (i_in_valid && samples_taken != samples_offered) begin
            // hold the beat until the block takes it
        end else if (gap_left > 0) begin
            gap_left = gap_left - 1;
            i_in_valid <= 1'b0;
        end else if (sample_feed_q.size() != 0) begin
            i_sample_us <= sample_feed_q.pop_front();
            i_in_valid  <= 1'b1;
            samples_offered = samples_offered + 1;
            if ($urandom_range(0, 15) == 0) in_burst = !in_burst;
            gap_left = in_burst ? 0 : $urandom_range(0, 9);
        end else begin
            i_in_valid <= 1'b0;
        end
    end

    // Output receiver: after each beat draw a stall, and burn it down only
    // while a result is being offered so the stall lands on real beats.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (results_seen != results_got) begin
                results_seen = results_got;
                if ($urandom_range(0, 15) == 0) out_burst = !out_burst;
                out_hold = out_burst ? 0 : $urandom_range(0, 9);
            end
            if (out_hold > 0) begin
                if (o_out_valid) out_hold = out_hold - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // Monitor: sample at the rising edge. Check the outgoing beat before
    // predicting from an incoming one, so the oldest prediction is matched.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hist_wp       = 0;
            hist_count    = 0;
            hist_degraded = 1'b0;
            cfg_window    = RST_WINDOW_LAST;
            cfg_min_count = RST_MIN_COUNT;
            cfg_threshold = RST_THRESHOLD_US;
            for (int i = 0; i < RING_DEPTH; i++) hist_ring[i] = '0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                results_got = results_got + 1;
                if (window_stats_q.size() == 0) begin
                    report_mismatch("unexpected beat, p95_us", 32'(o_p95_us), 32'd0);
                end else begin
                    want_stats = window_stats_q.pop_front();
                    if (o_p95_us !== want_stats.p95_us)
                        report_mismatch("p95_us", 32'(o_p95_us),
                                        32'(want_stats.p95_us));
                    if (o_sample_count !== want_stats.sample_count)
                        report_mismatch("sample_count", 32'(o_sample_count),
                                        32'(want_stats.sample_count));
                    if (o_window_used !== want_stats.window_used)
                        report_mismatch("window_used", 32'(o_window_used),
                                        32'(want_stats.window_used));
                    if (o_degraded !== want_stats.degraded)
                        report_mismatch("degraded", 32'(o_degraded),
                                        32'(want_stats.degraded));
                    if (int'(want_stats.window_used) > widest_window)
                        widest_window = int'(want_stats.window_used);
                    if (want_stats.sample_count == RING_DEPTH) saw_full_ring = 1'b1;
                    if (want_stats.degraded) saw_degraded = 1'b1;
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                reg_writes = reg_writes + 1;
                case (i_cfg_index)
                    CFG_WINDOW_LAST:  cfg_window    = i_cfg_data[WIN_W-1:0];
                    CFG_MIN_COUNT:    cfg_min_count = i_cfg_data[WIN_W-1:0];
                    CFG_THRESHOLD_US: cfg_threshold = i_cfg_data[TH_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && o_in_ready) begin
                samples_taken = samples_taken + 1;
                window_stats_q.insert(window_stats_q.size(),
                                      predict_window_stats(i_sample_us));
            end
        end
    end

    // Watchdog: end the run if it overstays the limit.
    always @(posedge i_clk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end
    end

    initial begin
        logic [WIN_W-1:0]            win_sel;
        logic [WIN_W-1:0]            min_sel;
        logic [TH_W-1:0]             th_sel;
        logic [CFG_DATA_W-WIN_W-1:0] junk;
        logic [US_W-1:0]             s;
        logic [US_W-1:0]             prev_sample;
        int                          random_samples;
        int                          phase_no;
        int                          len;
        bit                          wide_phase;

        random_samples = 0;
        phase_no       = 0;
        prev_sample    = '0;

        // Hold reset from time zero, release at a falling edge.
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset registers: huge samples exceed the threshold, but with fewer
        // than min_count stored the degrade check must not fire yet.
        repeat (4) feed_sample('1);
        wait_drain();

        // Window of one returns the sample itself: walk the bit patterns.
        // Junk above bit 6 of the window data must be dropped.
        write_reg(CFG_THRESHOLD_US, '1);
        write_reg(CFG_WINDOW_LAST, {17'h15A5A, 7'd1});
        @(posedge i_clk);
        feed_sample(24'h000000);
        feed_sample(24'hFFFFFF);
        feed_sample(24'hAAAAAA);
        feed_sample(24'h555555);
        feed_sample(24'h000001);
        wait_drain();

        // Window zero covers everything stored, duplicates included.
        write_reg(CFG_WINDOW_LAST, '0);
        @(posedge i_clk);
        feed_sample(24'd7);
        feed_sample(24'd7);
        feed_sample(24'd3);
        feed_sample(24'hFFFFFE);
        wait_drain();

        // Window wider than the ring is cut to the stored count; a write to
        // the undecoded index must leave every register alone.
        write_reg(CFG_WINDOW_LAST, 24'd127);
        write_reg(CFG_UNUSED_IDX, 24'($urandom));
        @(posedge i_clk);
        feed_sample(24'd12345);
        feed_sample(24'd99);
        wait_drain();

        // Zero min_count, percentile exactly at the threshold: no degrade.
        write_reg(CFG_WINDOW_LAST, 24'd1);
        write_reg(CFG_MIN_COUNT, '0);
        write_reg(CFG_THRESHOLD_US, 24'd10000);
        @(posedge i_clk);
        feed_sample(24'd10000);
        feed_sample(24'd9999);
        wait_drain();

        // Random phases: new registers each time, then a run of samples.
        // Every fifth phase, and the last ones, use a window near the ring size
        // and stay short, since a full window is the slowest case per sample.
        while (random_samples < RANDOM_SAMPLES) begin
            phase_no++;
            wide_phase = (phase_no % 5 == 4) || (random_samples >= RANDOM_SAMPLES - 3);
            if (wide_phase) begin
                case ($urandom_range(0, 2))
                    0:       win_sel = '0;
                    1:       win_sel = WIN_W'(RING_DEPTH);
                    default: win_sel = WIN_W'($urandom_range(121, 127));
                endcase
                len = 3;
            end else begin
                win_sel = WIN_W'($urandom_range(1, 32));
                len     = $urandom_range(8, 20);
            end
            case ($urandom_range(0, 3))
                0:       min_sel = '0;
                1:       min_sel = WIN_W'($urandom_range(120, 127));
                2:       min_sel = WIN_W'($urandom_range(0, 127));
                default: min_sel = WIN_W'($urandom_range(1, 10));
            endcase
            case ($urandom_range(0, 3))
                0:       th_sel = '0;
                1:       th_sel = '1;
                2:       th_sel = TH_W'($urandom);
                default: th_sel = TH_W'($urandom_range(5000, 20000));
            endcase

            if ($urandom_range(0, 3) == 0) write_reg(CFG_UNUSED_IDX, 24'($urandom));
            junk = $urandom_range(0, 1) ? 17'($urandom) : '0;
            write_reg(CFG_WINDOW_LAST, {junk, win_sel});
            junk = $urandom_range(0, 1) ? 17'($urandom) : '0;
            write_reg(CFG_MIN_COUNT, {junk, min_sel});
            write_reg(CFG_THRESHOLD_US, th_sel);
            @(posedge i_clk);

            // Mix full-range values, values near the threshold, repeats and
            // extremes so ties and saturated values land in the window.
            for (int i = 0; i < len; i++) begin
                case ($urandom_range(0, 4))
                    0:       s = US_W'($urandom);
                    1:       s = US_W'($urandom_range(0, 20000));
                    2:       s = prev_sample;
                    3:       s = $urandom_range(0, 1) ? '1 : '0;
                    default: s = US_W'($urandom_range(9990, 10010));
                endcase
                prev_sample = s;
                feed_sample(s);
                random_samples++;
            end
            wait_drain();
        end

        // Let the slowest possible computation run out, so a stray extra
        // beat would still be seen.
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (window_stats_q.size() != 0) begin
            report_mismatch("beats never returned", 32'd0, window_stats_q.size());
        end

        $display("summary: %0d samples, %0d beats checked, %0d register writes",
                 samples_taken, results_got, reg_writes);
        $display("summary: widest window %0d, ring filled %0d, degrade flag seen %0d",
                 widest_window, saw_full_ring, saw_degraded);
        if (error_count == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule

// File: sim.f
src/sw95_pkg.sv
src/sw95_ctrl.sv
src/sw95_dp.sv
src/sliding_window_p95_monitor.sv
dv/testbench.sv
